[hdl/dbd_pkg.sv]
// ============================================================================
// dbd_pkg
// Widths, constants and the month table shared by the days-between-dates
// unit and its checker.
// ============================================================================
`default_nettype none

package dbd_pkg;

  // Field widths
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIST_W  = 22;

  // Internal widths
  localparam int SUM_W   = YEAR_W + 1;   // year plus a rounding offset
  localparam int PROD_W  = 2 * SUM_W;    // reciprocal product
  localparam int J_W     = SUM_W - 2;    // ceil(n/4) and leap counts
  localparam int Q100_W  = 9;            // ceil(n/100)
  localparam int Q400_W  = 7;            // ceil(n/400)
  localparam int DBM_W   = 9;            // days before month
  localparam int DOY_W   = 10;           // day of year
  localparam int ABS_W   = 23;           // absolute day number
  localparam int DIFF_W  = ABS_W + 1;    // signed difference

  // Division by 100 and 400 as multiplication by a reciprocal.
  // Exact for every dividend below 43690, well above the 15-bit sums used.
  localparam logic [SUM_W-1:0] DIV_RECIP    = SUM_W'(20972);
  localparam int               DIV100_SHIFT = 21;
  localparam int               DIV400_SHIFT = 23;

  localparam logic [SUM_W-1:0] ROUND4   = SUM_W'(3);
  localparam logic [SUM_W-1:0] ROUND100 = SUM_W'(99);
  localparam logic [SUM_W-1:0] ROUND400 = SUM_W'(399);
  localparam logic [SUM_W-1:0] CENTURY  = SUM_W'(100);
  localparam logic [SUM_W-1:0] QUAD_CENTURY = SUM_W'(400);

  localparam logic [ABS_W-1:0]   COMMON_YEAR_DAYS = ABS_W'(365);
  localparam logic [MONTH_W-1:0] FEBRUARY         = MONTH_W'(2);

  localparam logic [YEAR_W-1:0] GREGORIAN_RESET = YEAR_W'(1583);
  localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};

  // Accept edge to result strobe, in clock cycles
  localparam int LATENCY = 6;

  // Days in the months before month m in a common year; months past
  // December count 31 days each, month zero has none before it.
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] r;
    case (m)
      4'd1:    r = DBM_W'(0);
      4'd2:    r = DBM_W'(31);
      4'd3:    r = DBM_W'(59);
      4'd4:    r = DBM_W'(90);
      4'd5:    r = DBM_W'(120);
      4'd6:    r = DBM_W'(151);
      4'd7:    r = DBM_W'(181);
      4'd8:    r = DBM_W'(212);
      4'd9:    r = DBM_W'(243);
      4'd10:   r = DBM_W'(273);
      4'd11:   r = DBM_W'(304);
      4'd12:   r = DBM_W'(334);
      4'd13:   r = DBM_W'(365);
      4'd14:   r = DBM_W'(396);
      4'd15:   r = DBM_W'(427);
      default: r = DBM_W'(0);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/days_between_dates_unit.sv]
// ============================================================================
// days_between_dates_unit
// Absolute number of days between two calendar dates, mixed Julian and
// Gregorian leap rule with a programmable cutover year.
// ============================================================================
// One date pair is taken on every clock cycle in which start is high and
// busy is low, so a new pair may follow on every cycle. The answer is on
// day_distance with done high for one cycle, once the pair has passed the
// stage registers s1 to s5 and the day_distance register. The unit is a
// fixed six-stage pipeline that never stalls, so results cannot be held
// off and must be captured while done is high. busy is a registered copy
// of rst, high only during reset and in the cycle after it. Each date is turned into an
// absolute day number (365 per year plus the leap years below it plus the
// day of year) and the two are subtracted; the divisions of the year by
// 100 and 400 use one reciprocal multiplier per divisor and per year, and
// the other products are by the constants 100, 400 and 365.
// gregorian_start_year is written through cfg_wen/cfg_wdata while no
// transaction is in flight; it resets to 1583. Dates are not checked, and
// distances above the 22-bit range saturate.
`default_nettype none

module days_between_dates_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [dbd_pkg::DAY_W-1:0]   first_day,
  input  wire logic [dbd_pkg::MONTH_W-1:0] first_month,
  input  wire logic [dbd_pkg::YEAR_W-1:0]  first_year,
  input  wire logic [dbd_pkg::DAY_W-1:0]   second_day,
  input  wire logic [dbd_pkg::MONTH_W-1:0] second_month,
  input  wire logic [dbd_pkg::YEAR_W-1:0]  second_year,
  input  wire logic                        cfg_wen,
  input  wire logic [dbd_pkg::YEAR_W-1:0]  cfg_wdata,
  output logic                             done,
  output logic [dbd_pkg::DIST_W-1:0]       day_distance
);

  // Lanes 0 and 1 carry the two dates, lane 2 the cutover year
  localparam int GL = 2;

  logic [dbd_pkg::YEAR_W-1:0] gregorian_start_year;

  // Stage 1: captured transaction
  logic                        v1;
  logic [dbd_pkg::YEAR_W-1:0]  s1_year  [3];
  logic [dbd_pkg::DAY_W-1:0]   s1_day   [2];
  logic [dbd_pkg::MONTH_W-1:0] s1_month [2];

  // Stage 2: quarter, century and quad-century counts
  logic                        v2;
  logic [dbd_pkg::YEAR_W-1:0]  s2_year  [3];
  logic [dbd_pkg::DAY_W-1:0]   s2_day   [2];
  logic [dbd_pkg::MONTH_W-1:0] s2_month [2];
  logic [dbd_pkg::J_W-1:0]     s2_j     [3];
  logic [dbd_pkg::Q100_W-1:0]  s2_q100  [3];
  logic [dbd_pkg::Q400_W-1:0]  s2_q400  [3];

  // Stage 3: Gregorian counts and leap flags
  logic                        v3;
  logic [dbd_pkg::YEAR_W-1:0]  s3_year  [3];
  logic [dbd_pkg::DAY_W-1:0]   s3_day   [2];
  logic [dbd_pkg::MONTH_W-1:0] s3_month [2];
  logic [dbd_pkg::J_W-1:0]     s3_j     [3];
  logic [dbd_pkg::J_W-1:0]     s3_g     [3];
  logic                        s3_leap  [2];

  // Stage 4: leap years below each year, day of year
  logic                        v4;
  logic [dbd_pkg::YEAR_W-1:0]  s4_year  [2];
  logic [dbd_pkg::J_W-1:0]     s4_leaps [2];
  logic [dbd_pkg::DOY_W-1:0]   s4_doy   [2];

  // Stage 5: absolute day numbers
  logic                        v5;
  logic [dbd_pkg::ABS_W-1:0]   s5_abs   [2];

  // Combinational values between stages
  logic [dbd_pkg::SUM_W-1:0]   sum4    [3];
  logic [dbd_pkg::SUM_W-1:0]   sum100  [3];
  logic [dbd_pkg::SUM_W-1:0]   sum400  [3];
  logic [dbd_pkg::PROD_W-1:0]  prod100 [3];
  logic [dbd_pkg::PROD_W-1:0]  prod400 [3];
  logic [dbd_pkg::SUM_W-1:0]   greg_sum [3];
  logic [dbd_pkg::SUM_W-1:0]   cent_mul [2];
  logic [dbd_pkg::SUM_W-1:0]   quad_mul [2];
  logic                        div4   [2];
  logic                        div100 [2];
  logic                        div400 [2];
  logic                        leap_next [2];
  logic [dbd_pkg::SUM_W-1:0]   leaps_sum [2];
  logic [dbd_pkg::DOY_W-1:0]   doy_next  [2];
  logic [dbd_pkg::ABS_W-1:0]   abs_next  [2];
  logic [dbd_pkg::DIFF_W-1:0]  diff;
  logic [dbd_pkg::DIFF_W-1:0]  mag;

  logic accept;
  assign accept = start && !busy;

  // Hold the cutover register; the user must write it only while no transaction is in flight, which is not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      gregorian_start_year <= dbd_pkg::GREGORIAN_RESET;
    end else if (cfg_wen) begin
      gregorian_start_year <= cfg_wdata;
    end
  end

  // Hold busy through reset and the cycle after it
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // Advance the valid bits; the pipeline never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // Stage 1: capture the dates and the cutover year
  always_ff @(posedge clk) begin
    s1_year[0]  <= first_year;
    s1_year[1]  <= second_year;
    s1_year[GL] <= gregorian_start_year;
    s1_day[0]   <= first_day;
    s1_day[1]   <= second_day;
    s1_month[0] <= first_month;
    s1_month[1] <= second_month;
  end

  // Stage 2: ceil(n/4) by a shift, ceil(n/100) and ceil(n/400) by reciprocal products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum4[k]    = dbd_pkg::SUM_W'(s1_year[k]) + dbd_pkg::ROUND4;
      sum100[k]  = dbd_pkg::SUM_W'(s1_year[k]) + dbd_pkg::ROUND100;
      sum400[k]  = dbd_pkg::SUM_W'(s1_year[k]) + dbd_pkg::ROUND400;
      prod100[k] = dbd_pkg::PROD_W'(sum100[k]) * dbd_pkg::PROD_W'(dbd_pkg::DIV_RECIP);
      prod400[k] = dbd_pkg::PROD_W'(sum400[k]) * dbd_pkg::PROD_W'(dbd_pkg::DIV_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s2_year[k] <= s1_year[k];
      s2_j[k]    <= sum4[k][dbd_pkg::SUM_W-1:2];
      s2_q100[k] <= prod100[k][dbd_pkg::DIV100_SHIFT +: dbd_pkg::Q100_W];
      s2_q400[k] <= prod400[k][dbd_pkg::DIV400_SHIFT +: dbd_pkg::Q400_W];
    end
    for (int k = 0; k < 2; k++) begin
      s2_day[k]   <= s1_day[k];
      s2_month[k] <= s1_month[k];
    end
  end

  // Stage 3: Gregorian leap counts; a year is a multiple of 100 exactly
  // when ceil(y/100) times 100 gives the year back, likewise for 400
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      greg_sum[k] = dbd_pkg::SUM_W'(s2_j[k]) - dbd_pkg::SUM_W'(s2_q100[k])
                  + dbd_pkg::SUM_W'(s2_q400[k]);
    end
    for (int k = 0; k < 2; k++) begin
      cent_mul[k] = dbd_pkg::SUM_W'(s2_q100[k]) * dbd_pkg::CENTURY;
      quad_mul[k] = dbd_pkg::SUM_W'(s2_q400[k]) * dbd_pkg::QUAD_CENTURY;
      div4[k]     = (s2_year[k][1:0] == 2'b00);
      div100[k]   = (cent_mul[k] == dbd_pkg::SUM_W'(s2_year[k]));
      div400[k]   = (quad_mul[k] == dbd_pkg::SUM_W'(s2_year[k]));
      if (s2_year[k] < s2_year[GL]) begin
        leap_next[k] = div4[k];
      end else begin
        leap_next[k] = div400[k] || (div4[k] && !div100[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s3_year[k] <= s2_year[k];
      s3_j[k]    <= s2_j[k];
      s3_g[k]    <= greg_sum[k][dbd_pkg::J_W-1:0];
    end
    for (int k = 0; k < 2; k++) begin
      s3_day[k]   <= s2_day[k];
      s3_month[k] <= s2_month[k];
      s3_leap[k]  <= leap_next[k];
    end
  end

  // Stage 4: leap years below each year under the mixed rule, day of year
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (s3_year[k] <= s3_year[GL]) begin
        leaps_sum[k] = dbd_pkg::SUM_W'(s3_j[k]);
      end else begin
        leaps_sum[k] = dbd_pkg::SUM_W'(s3_j[GL]) + dbd_pkg::SUM_W'(s3_g[k])
                     - dbd_pkg::SUM_W'(s3_g[GL]);
      end
      doy_next[k] = dbd_pkg::DOY_W'(s3_day[k])
                  + dbd_pkg::DOY_W'(dbd_pkg::days_before_month(s3_month[k]))
                  + dbd_pkg::DOY_W'((s3_month[k] > dbd_pkg::FEBRUARY) && s3_leap[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      s4_year[k]  <= s3_year[k];
      s4_leaps[k] <= leaps_sum[k][dbd_pkg::J_W-1:0];
      s4_doy[k]   <= doy_next[k];
    end
  end

  // Stage 5: absolute day number of each date
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      abs_next[k] = dbd_pkg::ABS_W'(s4_year[k]) * dbd_pkg::COMMON_YEAR_DAYS
                  + dbd_pkg::ABS_W'(s4_leaps[k]) + dbd_pkg::ABS_W'(s4_doy[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      s5_abs[k] <= abs_next[k];
    end
  end

  // Stage 6: subtract, take the magnitude, saturate
  always_comb begin
    diff = dbd_pkg::DIFF_W'(s5_abs[1]) - dbd_pkg::DIFF_W'(s5_abs[0]);
    mag  = diff[dbd_pkg::DIFF_W-1] ? (~diff + dbd_pkg::DIFF_W'(1)) : diff;
  end

  always_ff @(posedge clk) begin
    if (mag > dbd_pkg::DIFF_W'(dbd_pkg::DIST_MAX)) begin
      day_distance <= dbd_pkg::DIST_MAX;
    end else begin
      day_distance <= mag[dbd_pkg::DIST_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/dbd_checker.sv]
// ============================================================================
// dbd_checker
// Port-level checks of the days-between-dates unit, bound to its top level.
// ============================================================================
`default_nettype none

module dbd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [dbd_pkg::DAY_W-1:0]   first_day,
  input wire logic [dbd_pkg::MONTH_W-1:0] first_month,
  input wire logic [dbd_pkg::YEAR_W-1:0]  first_year,
  input wire logic [dbd_pkg::DAY_W-1:0]   second_day,
  input wire logic [dbd_pkg::MONTH_W-1:0] second_month,
  input wire logic [dbd_pkg::YEAR_W-1:0]  second_year,
  input wire logic                        done,
  input wire logic [dbd_pkg::DIST_W-1:0]  day_distance
);

  logic accept;
  assign accept = start && !busy;

  // Every accepted transaction produces a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(dbd_pkg::LATENCY) done)
    else $error("accepted transaction produced no result");

  // No result without a transaction accepted at the matching edge
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, dbd_pkg::LATENCY))
    else $error("result strobe without an accepted transaction");

  // Two dates in the same month of the same year differ by the day count
  a_same_month: assert property (@(posedge clk) disable iff (rst)
    (accept && first_year == second_year && first_month == second_month
     && second_day >= first_day)
    |-> ##(dbd_pkg::LATENCY)
    (day_distance == dbd_pkg::DIST_W'($past(second_day, dbd_pkg::LATENCY))
                   - dbd_pkg::DIST_W'($past(first_day, dbd_pkg::LATENCY))))
    else $error("wrong distance within one month");

endmodule

bind days_between_dates_unit dbd_checker u_dbd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .first_day    (first_day),
  .first_month  (first_month),
  .first_year   (first_year),
  .second_day   (second_day),
  .second_month (second_month),
  .second_year  (second_year),
  .done         (done),
  .day_distance (day_distance)
);

`default_nettype wire

[bench/tb_days_between_dates_unit.sv]
// ============================================================================
// tb_days_between_dates_unit
// Self-checking bench for the days-between-dates unit: a directed set of
// corner dates, a sweep of cutover years, then random date pairs under
// several cutover settings and sender idle patterns. Every transaction is
// predicted on acceptance and each strobed result is checked in order.
// ============================================================================

module tb_days_between_dates_unit;

  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_GAP         = 60;
  localparam int DRAIN_LIMIT     = 1000;
  localparam int IDLE_NONE       = 0;
  localparam int IDLE_HEAVY      = 86;
  localparam int IDLE_LIGHT      = 24;
  localparam logic [dbd_pkg::YEAR_W-1:0] YEAR_TOP = {dbd_pkg::YEAR_W{1'b1}};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [dbd_pkg::DAY_W-1:0]     first_day;
  logic [dbd_pkg::MONTH_W-1:0]   first_month;
  logic [dbd_pkg::YEAR_W-1:0]    first_year;
  logic [dbd_pkg::DAY_W-1:0]     second_day;
  logic [dbd_pkg::MONTH_W-1:0]   second_month;
  logic [dbd_pkg::YEAR_W-1:0]    second_year;
  logic                          cfg_wen;
  logic [dbd_pkg::YEAR_W-1:0]    cfg_wdata;
  logic                          done;
  logic [dbd_pkg::DIST_W-1:0]    day_distance;

  // Shadow of the cutover register and the distances still owed by the unit
  logic [dbd_pkg::YEAR_W-1:0]    cutover_year;
  logic [dbd_pkg::DIST_W-1:0]    pending_distances[$];
  logic [dbd_pkg::DIST_W-1:0]    owed_distance;
  int                            mismatches = 0;

  days_between_dates_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .first_day    (first_day),
    .first_month  (first_month),
    .first_year   (first_year),
    .second_day   (second_day),
    .second_month (second_month),
    .second_year  (second_year),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .done         (done),
    .day_distance (day_distance)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Calendar arithmetic
  // --------------------------------------------------------------------------

  // Leap years in [0, n-1] when every year follows the Julian rule
  function automatic longint julian_leaps_before(longint n);
    return (n + 3) / 4;
  endfunction

  // Leap years in [0, n-1] when every year follows the Gregorian rule
  function automatic longint gregorian_leaps_before(longint n);
    return (n + 3) / 4 - (n + 99) / 100 + (n + 399) / 400;
  endfunction

  // Leap years in [0, n-1]: Julian below the cutover, Gregorian from it on
  function automatic longint leaps_before(longint n);
    longint g;
    g = longint'(cutover_year);
    if (n <= g) return julian_leaps_before(n);
    return julian_leaps_before(g) + gregorian_leaps_before(n) - gregorian_leaps_before(g);
  endfunction

  function automatic bit leap_year(longint y);
    if (y < longint'(cutover_year)) return (y % 4) == 0;
    return (y % 400) == 0 || ((y % 4) == 0 && (y % 100) != 0);
  endfunction

  // Day of month plus the months before it and any leap day; months past December run 31 days
  function automatic longint day_of_year(longint y, longint m, longint d);
    longint r;
    r = d;
    for (int k = 1; k < m; k++) begin
      case (k)
        2:            r += 28;
        4, 6, 9, 11:  r += 30;
        default:      r += 31;
      endcase
    end
    if (m > 2 && leap_year(y)) r += 1;
    return r;
  endfunction

  // Count days from year zero so that the distance is one subtraction
  function automatic longint day_number(longint y, longint m, longint d);
    return 365 * y + leaps_before(y) + day_of_year(y, m, d);
  endfunction

  function automatic logic [dbd_pkg::DIST_W-1:0] predicted_distance(
    logic [dbd_pkg::DAY_W-1:0] d1, logic [dbd_pkg::MONTH_W-1:0] m1,
    logic [dbd_pkg::YEAR_W-1:0] y1,
    logic [dbd_pkg::DAY_W-1:0] d2, logic [dbd_pkg::MONTH_W-1:0] m2,
    logic [dbd_pkg::YEAR_W-1:0] y2);
    longint span;
    span = day_number(longint'(y2), longint'(m2), longint'(d2))
         - day_number(longint'(y1), longint'(m1), longint'(d1));
    if (span < 0) span = -span;
    if (span > longint'(dbd_pkg::DIST_MAX)) span = longint'(dbd_pkg::DIST_MAX);
    return dbd_pkg::DIST_W'(span);
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  // Match each strobed distance against the oldest one still owed
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_distances.size() == 0) begin
        $error("day_distance: expected nothing, actual %0d", day_distance);
        mismatches++;
      end else begin
        owed_distance = pending_distances.pop_front();
        if (day_distance !== owed_distance) begin
          $error("day_distance: expected %0d, actual %0d", owed_distance, day_distance);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Offer one date pair after a random idle gap; predict it once accepted
  task automatic send_dates(
    input logic [dbd_pkg::DAY_W-1:0] d1, input logic [dbd_pkg::MONTH_W-1:0] m1,
    input logic [dbd_pkg::YEAR_W-1:0] y1,
    input logic [dbd_pkg::DAY_W-1:0] d2, input logic [dbd_pkg::MONTH_W-1:0] m2,
    input logic [dbd_pkg::YEAR_W-1:0] y2,
    input int idle_pct);
    int gap;
    gap = 0;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct && gap < MAX_GAP) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    first_day    <= d1;
    first_month  <= m1;
    first_year   <= y1;
    second_day   <= d2;
    second_month <= m2;
    second_year  <= y2;
    do @(posedge clk); while (busy);
    pending_distances.push_back(predicted_distance(d1, m1, y1, d2, m2, y2));
  endtask

  // Drop start and wait for every owed distance, then for the pipeline to empty
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_distances.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (dbd_pkg::LATENCY + 2) @(posedge clk);
    if (pending_distances.size() != 0) begin
      $error("day_distance: %0d results never arrived", pending_distances.size());
      mismatches++;
      pending_distances.delete();
    end
  endtask

  task automatic write_cutover(input logic [dbd_pkg::YEAR_W-1:0] year);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= year;
    @(posedge clk);
    cutover_year = year;
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [dbd_pkg::YEAR_W-1:0] random_year();
    int pick;
    int near;
    pick = $urandom_range(9);
    if (pick < 4) return dbd_pkg::YEAR_W'($urandom_range(16383));
    if (pick < 7) begin
      near = int'(cutover_year) + int'($urandom_range(8)) - 4;
      if (near < 0) near = 0;
      if (near > 16383) near = 16383;
      return dbd_pkg::YEAR_W'(near);
    end
    return dbd_pkg::YEAR_W'($urandom_range(9999, 1));
  endfunction

  function automatic logic [dbd_pkg::DAY_W-1:0] random_day();
    if ($urandom_range(9) < 8) return dbd_pkg::DAY_W'($urandom_range(31, 1));
    return dbd_pkg::DAY_W'($urandom_range(31));
  endfunction

  function automatic logic [dbd_pkg::MONTH_W-1:0] random_month();
    if ($urandom_range(9) < 8) return dbd_pkg::MONTH_W'($urandom_range(12, 1));
    return dbd_pkg::MONTH_W'($urandom_range(15));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Ordinary dates under the reset cutover year
  task automatic test_reset_cutover();
    send_dates(5'd14, 4'd7, 14'd1999, 5'd14, 4'd7, 14'd1999, IDLE_NONE);
    send_dates(5'd1, 4'd1, 14'd1999, 5'd31, 4'd12, 14'd1999, IDLE_NONE);
    send_dates(5'd31, 4'd12, 14'd2024, 5'd1, 4'd1, 14'd2024, IDLE_NONE);
    // The calendar change: no days dropped between the old and new rule
    send_dates(5'd4, 4'd10, 14'd1582, 5'd15, 4'd10, 14'd1583, IDLE_NONE);
    // Julian century leap year against Gregorian century common year
    send_dates(5'd28, dbd_pkg::FEBRUARY, 14'd1500, 5'd1, 4'd3, 14'd1500, IDLE_NONE);
    send_dates(5'd28, dbd_pkg::FEBRUARY, 14'd1700, 5'd1, 4'd3, 14'd1700, IDLE_NONE);
    send_dates(5'd1, 4'd3, 14'd2000, 5'd28, dbd_pkg::FEBRUARY, 14'd1600, IDLE_NONE);
  endtask

  // Field values outside the calendar and the far ends of the year range
  task automatic test_field_extremes();
    send_dates(5'd0, 4'd0, 14'd0, 5'd0, 4'd0, 14'd0, IDLE_NONE);
    send_dates(5'd31, 4'd15, YEAR_TOP, 5'd31, 4'd15, YEAR_TOP, IDLE_NONE);
    // Far enough apart to saturate, in both orders
    send_dates(5'd0, 4'd0, 14'd0, 5'd31, 4'd15, YEAR_TOP, IDLE_NONE);
    send_dates(5'd31, 4'd12, YEAR_TOP, 5'd1, 4'd1, 14'd1, IDLE_NONE);
    send_dates(5'd31, dbd_pkg::FEBRUARY, 14'd2023, 5'd1, 4'd3, 14'd2023, IDLE_NONE);
    send_dates(5'd31, 4'd0, 14'd0, 5'd1, 4'd13, 14'd1, IDLE_NONE);
    send_dates(5'd1, 4'd14, 14'd4, 5'd0, 4'd3, 14'd5, IDLE_NONE);
  endtask

  // Cutover register at its extremes and at common historical values
  task automatic test_cutover_settings();
    write_cutover(14'd0);
    send_dates(5'd28, dbd_pkg::FEBRUARY, 14'd1900, 5'd1, 4'd3, 14'd1900, IDLE_NONE);
    send_dates(5'd1, 4'd1, 14'd0, 5'd1, 4'd1, 14'd401, IDLE_NONE);
    write_cutover(YEAR_TOP);
    send_dates(5'd28, dbd_pkg::FEBRUARY, 14'd1900, 5'd1, 4'd3, 14'd1900, IDLE_NONE);
    send_dates(5'd1, 4'd1, 14'd16000, 5'd1, 4'd3, YEAR_TOP, IDLE_NONE);
    write_cutover(14'd1);
    send_dates(5'd31, 4'd12, 14'd0, 5'd1, 4'd1, 14'd1, IDLE_NONE);
    write_cutover(14'd1752);
    send_dates(5'd2, 4'd9, 14'd1751, 5'd14, 4'd9, 14'd1753, IDLE_NONE);
    write_cutover(dbd_pkg::GREGORIAN_RESET);
    send_dates(5'd29, dbd_pkg::FEBRUARY, 14'd1582, 5'd29, dbd_pkg::FEBRUARY, 14'd1584,
               IDLE_NONE);
  endtask

  // Random pairs over several cutover years and sender idle patterns
  task automatic test_random_pairs();
    logic [dbd_pkg::YEAR_W-1:0] settings[6];
    int                         idle_pcts[3];
    logic [dbd_pkg::YEAR_W-1:0] y1;
    logic [dbd_pkg::YEAR_W-1:0] y2;
    settings  = '{dbd_pkg::GREGORIAN_RESET, '0, YEAR_TOP, 14'd1752,
                  dbd_pkg::YEAR_W'($urandom_range(16383)),
                  dbd_pkg::YEAR_W'($urandom_range(9999, 1))};
    idle_pcts = '{IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT};
    foreach (settings[s]) begin
      write_cutover(settings[s]);
      foreach (idle_pcts[p]) begin
        repeat (ITEMS_PER_PHASE) begin
          y1 = random_year();
          // Keep a fair share within one year to work the same-year path
          y2 = ($urandom_range(4) == 0) ? y1 : random_year();
          send_dates(random_day(), random_month(), y1,
                     random_day(), random_month(), y2, idle_pcts[p]);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    first_day    = '0;
    first_month  = '0;
    first_year   = '0;
    second_day   = '0;
    second_month = '0;
    second_year  = '0;
    cfg_wen      = 1'b0;
    cfg_wdata    = '0;
    cutover_year = dbd_pkg::GREGORIAN_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_cutover();
    test_field_extremes();
    test_cutover_settings();
    test_random_pairs();

    drain_results();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
